// File: sv/mts_pkg.sv
// Shared types, widths and codes for the monthly temperature statistics block.
package mts_pkg;

  localparam int COUNT_BITS    = 20;
  localparam int TEMP_BITS     = 16;
  localparam int FRACTION_BITS = 8;
  localparam int AVG_BITS      = 24;
  localparam int MONTHS        = 12;
  localparam int MONTH_BITS    = 4;
  localparam int BIN_BITS      = $clog2(MONTHS);
  localparam int SUM_BITS      = COUNT_BITS + TEMP_BITS;
  localparam int DVD_BITS      = SUM_BITS + FRACTION_BITS;
  localparam int STEP_BITS     = $clog2(DVD_BITS + 1);

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                  func;
    logic [MONTH_BITS-1:0]       month;
    logic signed [TEMP_BITS-1:0] temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [AVG_BITS-1:0]  month_average;
    logic signed [TEMP_BITS-1:0] month_minimum;
    logic signed [TEMP_BITS-1:0] month_maximum;
    logic [COUNT_BITS-1:0]       month_count;
    logic signed [AVG_BITS-1:0]  total_average;
    logic signed [TEMP_BITS-1:0] total_minimum;
    logic signed [TEMP_BITS-1:0] total_maximum;
    logic [COUNT_BITS-1:0]       total_count;
    logic                        add_dropped;
  } out_word_t;

  // Classified item as it sits in the queue between front and back.
  typedef struct packed {
    op_t                         op;
    logic                        bin_ok;
    logic [BIN_BITS-1:0]         bin;
    logic signed [TEMP_BITS-1:0] temperature;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// File: sv/mts_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module mts_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mts_pkg::in_word_t   in_data,
  output mts_pkg::queue_head_t head,
  input  logic                pop
);
  import mts_pkg::*;

  item_t      cls;
  item_t      q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  always_comb begin
    cls.temperature = in_data.temperature;
    cls.bin_ok      = (in_data.month >= MONTH_BITS'(1)) && (in_data.month <= MONTH_BITS'(MONTHS));
    cls.bin         = cls.bin_ok ? BIN_BITS'(in_data.month - MONTH_BITS'(1)) : '0;
    case (in_data.func)
      FUNC_ADD:   cls.op = OP_ADD;
      FUNC_QUERY: cls.op = OP_QUERY;
      FUNC_CLEAR: cls.op = OP_CLEAR;
      default:    cls.op = OP_QUERY;
    endcase
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0)
    else $error("queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// File: sv/mts_div.sv
// Restoring divider, one quotient bit per cycle.
module mts_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [mts_pkg::DVD_BITS-1:0]       dividend,
  input  logic [mts_pkg::COUNT_BITS-1:0]     divisor,
  output logic                               done,
  output logic [mts_pkg::DVD_BITS-1:0]       quotient
);
  import mts_pkg::*;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  logic [DVD_BITS-1:0]   acc_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] dsr_r;
  logic [STEP_BITS-1:0]  step_r;
  logic                  busy_r;
  logic                  done_r;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  always_comb begin
    shifted = {rem_r, acc_r[DVD_BITS-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = !diff[COUNT_BITS];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[DVD_BITS-2:0], ge};
      rem_r <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_BITS'(DVD_BITS);
    end else begin
      done_r <= busy_r && (step_r == STEP_BITS'(1));
      if (busy_r) begin
        step_r <= step_r - STEP_BITS'(1);
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

// File: sv/mts_back.sv
// Back end: updates the bins, forms both averages and holds the result word.
module mts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mts_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mts_pkg::out_word_t   out_data
);
  import mts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SUM_BITS-1:0]  bin_sum_r  [MONTHS];
  logic [COUNT_BITS-1:0]       bin_cnt_r  [MONTHS];
  logic signed [TEMP_BITS-1:0] bin_low_r  [MONTHS];
  logic signed [TEMP_BITS-1:0] bin_high_r [MONTHS];
  logic signed [SUM_BITS-1:0]  all_sum_r;
  logic [COUNT_BITS-1:0]       all_cnt_r;
  logic signed [TEMP_BITS-1:0] all_low_r, all_high_r;

  // Post-update copy of the two groups that this word reports.
  logic signed [SUM_BITS-1:0]  m_sum_r, t_sum_r;
  logic [COUNT_BITS-1:0]       m_cnt_r, t_cnt_r;
  logic signed [TEMP_BITS-1:0] m_low_r, m_high_r, t_low_r, t_high_r;
  logic                        drop_r, m_neg_r, t_neg_r;

  logic                        out_valid_r;
  out_word_t                   out_data_r;

  item_t                       it;
  logic signed [SUM_BITS-1:0]  t_ext, cur_sum, nb_sum, na_sum;
  logic [COUNT_BITS-1:0]       cur_cnt;
  logic signed [TEMP_BITS-1:0] cur_low, cur_high, nb_low, nb_high, na_low, na_high;
  logic                        full, do_add, add_bin, out_free;
  logic [SUM_BITS-1:0]         m_mag, t_mag;
  logic [DVD_BITS-1:0]         m_q, t_q;
  logic                        m_done, t_done, div_start;

  function automatic logic signed [AVG_BITS-1:0] finish(input logic [DVD_BITS-1:0] q,
                                                         input logic neg);
    logic [DVD_BITS-1:0] limit;
    logic [AVG_BITS-1:0] res;
    limit = neg ? (DVD_BITS'(1) << (AVG_BITS - 1))
                : ((DVD_BITS'(1) << (AVG_BITS - 1)) - DVD_BITS'(1));
    res   = (q > limit) ? limit[AVG_BITS-1:0] : q[AVG_BITS-1:0];
    return neg ? -res : res;
  endfunction

  assign it  = head.item;
  assign pop = (state_r == S_IDLE) && head.valid;

  always_comb begin
    t_ext    = SUM_BITS'(it.temperature);
    cur_sum  = bin_sum_r[it.bin];
    cur_cnt  = bin_cnt_r[it.bin];
    cur_low  = bin_low_r[it.bin];
    cur_high = bin_high_r[it.bin];
    full     = (all_cnt_r == '1);
    do_add   = (it.op == OP_ADD) && !full;
    add_bin  = do_add && it.bin_ok;
    nb_sum   = cur_sum + t_ext;
    nb_low   = (cur_cnt == '0 || it.temperature < cur_low) ? it.temperature : cur_low;
    nb_high  = (cur_cnt == '0 || it.temperature > cur_high) ? it.temperature : cur_high;
    na_sum   = all_sum_r + t_ext;
    na_low   = (all_cnt_r == '0 || it.temperature < all_low_r) ? it.temperature : all_low_r;
    na_high  = (all_cnt_r == '0 || it.temperature > all_high_r) ? it.temperature : all_high_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MONTHS; i++) begin
        bin_sum_r[i]  <= '0;
        bin_cnt_r[i]  <= '0;
        bin_low_r[i]  <= '0;
        bin_high_r[i] <= '0;
      end
      all_sum_r  <= '0;
      all_cnt_r  <= '0;
      all_low_r  <= '0;
      all_high_r <= '0;
    end else if (pop) begin
      if (it.op == OP_CLEAR) begin
        for (int i = 0; i < MONTHS; i++) begin
          bin_sum_r[i]  <= '0;
          bin_cnt_r[i]  <= '0;
          bin_low_r[i]  <= '0;
          bin_high_r[i] <= '0;
        end
        all_sum_r  <= '0;
        all_cnt_r  <= '0;
        all_low_r  <= '0;
        all_high_r <= '0;
      end else if (do_add) begin
        all_sum_r  <= na_sum;
        all_cnt_r  <= all_cnt_r + COUNT_BITS'(1);
        all_low_r  <= na_low;
        all_high_r <= na_high;
        if (it.bin_ok) begin
          bin_sum_r[it.bin]  <= nb_sum;
          bin_cnt_r[it.bin]  <= cur_cnt + COUNT_BITS'(1);
          bin_low_r[it.bin]  <= nb_low;
          bin_high_r[it.bin] <= nb_high;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      drop_r <= (it.op == OP_ADD) && full;
      if (!it.bin_ok || it.op == OP_CLEAR) begin
        m_sum_r  <= '0;
        m_cnt_r  <= '0;
        m_low_r  <= '0;
        m_high_r <= '0;
      end else if (add_bin) begin
        m_sum_r  <= nb_sum;
        m_cnt_r  <= cur_cnt + COUNT_BITS'(1);
        m_low_r  <= nb_low;
        m_high_r <= nb_high;
      end else begin
        m_sum_r  <= cur_sum;
        m_cnt_r  <= cur_cnt;
        m_low_r  <= cur_low;
        m_high_r <= cur_high;
      end
      if (it.op == OP_CLEAR) begin
        t_sum_r  <= '0;
        t_cnt_r  <= '0;
        t_low_r  <= '0;
        t_high_r <= '0;
      end else if (do_add) begin
        t_sum_r  <= na_sum;
        t_cnt_r  <= all_cnt_r + COUNT_BITS'(1);
        t_low_r  <= na_low;
        t_high_r <= na_high;
      end else begin
        t_sum_r  <= all_sum_r;
        t_cnt_r  <= all_cnt_r;
        t_low_r  <= all_low_r;
        t_high_r <= all_high_r;
      end
    end
    if (div_start) begin
      m_neg_r <= m_sum_r[SUM_BITS-1];
      t_neg_r <= t_sum_r[SUM_BITS-1];
    end
  end

  // Both dividers see a magnitude scaled by the fraction bits; the sign goes back on after.
  assign div_start = (state_r == S_LOAD);
  assign m_mag     = m_sum_r[SUM_BITS-1] ? SUM_BITS'(-m_sum_r) : SUM_BITS'(m_sum_r);
  assign t_mag     = t_sum_r[SUM_BITS-1] ? SUM_BITS'(-t_sum_r) : SUM_BITS'(t_sum_r);

  mts_div u_div_month (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_BITS'(m_mag) << FRACTION_BITS),
    .divisor  (m_cnt_r),
    .done     (m_done),
    .quotient (m_q)
  );

  mts_div u_div_total (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_BITS'(t_mag) << FRACTION_BITS),
    .divisor  (t_cnt_r),
    .done     (t_done),
    .quotient (t_q)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (head.valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (m_done) state_nxt = S_PUT;
      S_PUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PUT && out_free) begin
      out_data_r.month_average <= (m_cnt_r == '0) ? '0 : finish(m_q, m_neg_r);
      out_data_r.month_minimum <= (m_cnt_r == '0) ? '0 : m_low_r;
      out_data_r.month_maximum <= (m_cnt_r == '0) ? '0 : m_high_r;
      out_data_r.month_count   <= m_cnt_r;
      out_data_r.total_average <= (t_cnt_r == '0) ? '0 : finish(t_q, t_neg_r);
      out_data_r.total_minimum <= (t_cnt_r == '0) ? '0 : t_low_r;
      out_data_r.total_maximum <= (t_cnt_r == '0) ? '0 : t_high_r;
      out_data_r.total_count   <= t_cnt_r;
      out_data_r.add_dropped   <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (m_done || t_done) |-> (state_r == S_DIV && m_done == t_done))
    else $error("divider finished outside the divide phase");
  a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.month_count <= out_data_r.total_count)
    else $error("month count exceeds total count");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.add_dropped) |-> out_data_r.total_count == '1)
    else $error("add dropped while total count not saturated");
`endif

endmodule

// File: sv/monthly_temperature_statistics.sv
// Top level of the monthly temperature statistics block.
module monthly_temperature_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mts_pkg::out_word_t out_data
);
  // Each input word (add, query or clear) yields one result word with the month and
  // whole-set average, minimum, maximum and count after the word has taken effect.
  // In the back end a word passes through these steps in order: the bins are updated as it is
  // popped, the dividers are loaded, the two bit-serial dividers run side by side on the
  // 44-bit scaled sums, and the result is clamped and registered. A two-word queue
  // sits in front, and the result register lets the next word start while a finished
  // result is still stalled.
  import mts_pkg::*;

  queue_head_t head;
  logic        pop;

  mts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  mts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: bench/testbench.sv
// Self-checking bench for the monthly temperature statistics block.
module testbench;
  import mts_pkg::*;

  localparam logic [1:0]  FUNC_SPARE    = 2'd3;
  localparam int unsigned COUNT_TOP     = (1 << COUNT_BITS) - 1;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          RANDOM_ITEMS  = 1800;
  localparam int          QUIET_TAIL    = 200;

  typedef struct {
    in_word_t word;
    bit       wait_drain;
    int       idle_pct;
  } stim_t;

  typedef struct packed {
    logic signed [AVG_BITS-1:0]  avg;
    logic signed [TEMP_BITS-1:0] lo;
    logic signed [TEMP_BITS-1:0] hi;
    logic [COUNT_BITS-1:0]       cnt;
  } group_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  stim_t     stim_q[$];
  out_word_t expected_q[$];
  int        outstanding = 0;
  int        rx_idle_pct = 0;
  int        gap_left    = 0;
  int        stall_left  = 0;
  int        errors      = 0;

  // Running tallies of the twelve months and of the whole set.
  longint                      mon_sum[MONTHS];
  int unsigned                 mon_cnt[MONTHS];
  logic signed [TEMP_BITS-1:0] mon_lo[MONTHS];
  logic signed [TEMP_BITS-1:0] mon_hi[MONTHS];
  longint                      year_sum;
  int unsigned                 year_cnt;
  logic signed [TEMP_BITS-1:0] year_lo;
  logic signed [TEMP_BITS-1:0] year_hi;

  monthly_temperature_statistics uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_tallies();
    for (int i = 0; i < MONTHS; i++) begin
      mon_sum[i] = 0;
      mon_cnt[i] = 0;
      mon_lo[i]  = '0;
      mon_hi[i]  = '0;
    end
    year_sum = 0;
    year_cnt = 0;
    year_lo  = '0;
    year_hi  = '0;
  endfunction

  // Mean scaled by 2^FRACTION_BITS, truncated toward zero and clamped.
  function automatic logic signed [AVG_BITS-1:0] fixed_mean(longint total, int unsigned n);
    longint unsigned mag, cap, q;
    mag = (total < 0) ? longint'(-total) : longint'(total);
    cap = (total < 0) ? (64'd1 << (AVG_BITS - 1)) : (64'd1 << (AVG_BITS - 1)) - 1;
    q = (mag << FRACTION_BITS) / n;
    if (q > cap) q = cap;
    return (total < 0) ? AVG_BITS'(-q) : AVG_BITS'(q);
  endfunction

  function automatic group_t summarize(longint total, int unsigned n,
                                       logic signed [TEMP_BITS-1:0] lo,
                                       logic signed [TEMP_BITS-1:0] hi);
    group_t g;
    g = '0;
    if (n != 0) begin
      g.avg = fixed_mean(total, n);
      g.lo  = lo;
      g.hi  = hi;
      g.cnt = COUNT_BITS'(n);
    end
    return g;
  endfunction

  // Updates the tallies for one word and returns the result it should produce.
  function automatic out_word_t apply_record(in_word_t w);
    out_word_t r;
    group_t    g;
    bit        in_bin;
    int        b;
    r = '0;
    in_bin = (w.month >= 1 && w.month <= MONTHS);
    b = in_bin ? w.month - 1 : 0;
    if (w.func == OP_CLEAR) begin
      clear_tallies();
    end else if (w.func == OP_ADD) begin
      if (year_cnt >= COUNT_TOP) begin
        r.add_dropped = 1'b1;
      end else begin
        if (year_cnt == 0 || w.temperature < year_lo) year_lo = w.temperature;
        if (year_cnt == 0 || w.temperature > year_hi) year_hi = w.temperature;
        year_sum += longint'(w.temperature);
        year_cnt++;
        if (in_bin) begin
          if (mon_cnt[b] == 0 || w.temperature < mon_lo[b]) mon_lo[b] = w.temperature;
          if (mon_cnt[b] == 0 || w.temperature > mon_hi[b]) mon_hi[b] = w.temperature;
          mon_sum[b] += longint'(w.temperature);
          mon_cnt[b]++;
        end
      end
    end
    if (in_bin) begin
      g = summarize(mon_sum[b], mon_cnt[b], mon_lo[b], mon_hi[b]);
      r.month_average = g.avg;
      r.month_minimum = g.lo;
      r.month_maximum = g.hi;
      r.month_count   = g.cnt;
    end
    g = summarize(year_sum, year_cnt, year_lo, year_hi);
    r.total_average = g.avg;
    r.total_minimum = g.lo;
    r.total_maximum = g.hi;
    r.total_count   = g.cnt;
    return r;
  endfunction

  function automatic void queue_word(logic [1:0] f, int m, int t, int pct, bit drain);
    stim_t s;
    s.word.func        = f;
    s.word.month       = m[MONTH_BITS-1:0];
    s.word.temperature = t[TEMP_BITS-1:0];
    s.wait_drain       = drain;
    s.idle_pct         = pct;
    stim_q.push_back(s);
  endfunction

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: presents the head of the stimulus queue and holds it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) void'(stim_q.pop_front());
      if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q[0].wait_drain && (in_valid || outstanding != 0)) begin
        // Hold off until the block has returned every pending word.
        in_valid <= 1'b0;
      end else begin
        in_valid    <= 1'b1;
        in_data     <= stim_q[0].word;
        rx_idle_pct <= stim_q[0].idle_pct;
        if ($urandom_range(0, 99) < stim_q[0].idle_pct) gap_left = $urandom_range(1, 5);
      end
    end
  end

  // Receiver stalls come in short bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted input word and checks each accepted result.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(apply_record(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_q.pop_front();
          check_field("month_average", 32'(out_data.month_average),
                      32'(want.month_average));
          check_field("month_minimum", 32'(out_data.month_minimum),
                      32'(want.month_minimum));
          check_field("month_maximum", 32'(out_data.month_maximum),
                      32'(want.month_maximum));
          check_field("month_count",   32'(out_data.month_count),
                      32'(want.month_count));
          check_field("total_average", 32'(out_data.total_average),
                      32'(want.total_average));
          check_field("total_minimum", 32'(out_data.total_minimum),
                      32'(want.total_minimum));
          check_field("total_maximum", 32'(out_data.total_maximum),
                      32'(want.total_maximum));
          check_field("total_count",   32'(out_data.total_count),
                      32'(want.total_count));
          check_field("add_dropped",   32'(out_data.add_dropped),
                      32'(want.add_dropped));
        end
      end
      outstanding <= expected_q.size();
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int pick, m, t, pct;
    logic [1:0] f;
    clear_tallies();

    // Empty bins, out-of-range months and the extremes of the reading.
    queue_word(OP_QUERY, 1, 0, 20, 1'b0);
    queue_word(OP_QUERY, 0, 0, 20, 1'b0);
    queue_word(OP_ADD, 1, 32767, 20, 1'b0);
    queue_word(OP_ADD, 1, -32768, 20, 1'b0);
    queue_word(OP_ADD, 12, -32768, 20, 1'b0);
    queue_word(OP_ADD, 12, -32768, 20, 1'b0);
    queue_word(OP_ADD, 0, 100, 20, 1'b0);
    queue_word(OP_ADD, 13, -5, 20, 1'b0);
    queue_word(OP_ADD, 15, 7, 20, 1'b0);
    queue_word(FUNC_SPARE, 12, -1, 20, 1'b0);
    queue_word(OP_QUERY, 15, 0, 20, 1'b0);
    // A negative mean that is not a whole number truncates toward zero.
    queue_word(OP_ADD, 2, -1, 20, 1'b0);
    queue_word(OP_ADD, 2, -1, 20, 1'b0);
    queue_word(OP_ADD, 2, 0, 20, 1'b0);
    queue_word(OP_ADD, 3, 32767, 20, 1'b0);
    queue_word(OP_ADD, 3, 32767, 20, 1'b0);
    queue_word(OP_CLEAR, 5, 1234, 20, 1'b0);
    queue_word(OP_QUERY, 1, 0, 20, 1'b0);
    queue_word(OP_QUERY, 12, 0, 20, 1'b0);
    queue_word(OP_ADD, 7, 0, 20, 1'b0);
    queue_word(FUNC_SPARE, 7, 32767, 20, 1'b0);
    queue_word(OP_QUERY, 7, -32768, 20, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) f = OP_ADD;
      else if (pick < 92) f = OP_QUERY;
      else if (pick < 99) f = FUNC_SPARE;
      else f = OP_CLEAR;
      if ($urandom_range(0, 99) < 85) begin
        m = $urandom_range(1, 12);
      end else begin
        m = $urandom_range(0, 3);
        if (m > 0) m += MONTHS;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) t = -32768;
      else if (pick < 20) t = 32767;
      else if (pick < 55) t = $urandom_range(0, 100) - 50;
      else t = $urandom_range(0, 65535);
      if (i >= RANDOM_ITEMS - QUIET_TAIL) pct = 0;
      else case ((i / 150) % 3)
        0: pct = 40;
        1: pct = 10;
        default: pct = 0;
      endcase
      queue_word(f, m, t, pct, i == RANDOM_ITEMS / 2);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
